[rtl/csma_pkg.sv]
// Types and constants shared by the CSMA/CA station sender.
package csma_pkg;

  localparam logic [2:0] CMD_ENQ_DATA = 3'd0;
  localparam logic [2:0] CMD_ENQ_ACK  = 3'd1;
  localparam logic [2:0] CMD_TICK     = 3'd2;
  localparam logic [2:0] CMD_ACK_RX   = 3'd3;
  localparam logic [2:0] CMD_TIMEOUT  = 3'd4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES    = 2'd1;

  localparam logic [9:0] BACKOFF_WINDOW_RST = 10'd400;
  localparam logic [2:0] MAX_RETRIES_RST    = 3'd3;

  localparam logic [16:0] DRAW_MAX      = 17'd8191;
  localparam logic [3:0]  ATTEMPT_MAX   = 4'd15;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  peer;
    logic [15:0] frame_ref;
    logic [15:0] random_draw;
  } in_item_t;

  typedef struct packed {
    logic        sent;
    logic        sent_is_ack;
    logic [5:0]  sent_dest;
    logic [15:0] sent_id;
    logic        start_timer;
    logic        dropped_now;
    logic        queue_full;
    logic [15:0] drop_total;
    logic [4:0]  pending;
  } out_item_t;

  typedef struct packed {
    logic        is_ack;
    logic [5:0]  dest;
    logic [15:0] ack_id;
  } frame_t;

endpackage

[rtl/csma_station_backoff_sender.sv]
// CSMA/CA station sender: frame queue, random backoff and retransmission control.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_data  (command, peer, frame_ref, random_draw)
//  out_    | output    | out_valid/out_stall| out_data (send, drop and queue status)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// Each item goes through an accept state, two passes through the shared
// 16x16 multiplier (window, then random_draw * window), and an update state.
// The update state waits while the output register still holds a result that is
// stalled; a new item is accepted once the update has been committed.
// Reset is synchronous and active low; the frame queue itself is not cleared.
module csma_station_backoff_sender #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  csma_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output csma_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csma_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import csma_pkg::*;

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WIN  = 2'd1;
  localparam logic [1:0] ST_DRAW = 2'd2;
  localparam logic [1:0] ST_EXEC = 2'd3;

  logic [1:0]        state_r, state_nxt;
  in_item_t          item_r;
  logic [31:0]       prod_r;
  logic [9:0]        bw_r;
  logic [2:0]        maxr_r;

  logic              idle_r, idle_nxt;
  logic [12:0]       count_r, count_nxt;
  logic [15:0]       fc_r, fc_nxt;
  logic [3:0]        attempt_r, attempt_nxt;
  logic [15:0]       drop_r, drop_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  frame_t            fifo_mem [QUEUE_DEPTH];
  frame_t            mem_rd_r;
  frame_t            mem_wdata;
  logic              mem_we;

  logic              out_valid_r;
  out_item_t         out_data_r, res;

  logic [15:0]       mul_a, mul_b;
  logic [31:0]       mul_p;
  logic              widen;
  logic [4:0]        attempt_inc;
  logic [16:0]       draw_sum;
  logic [12:0]       draw;
  logic              commit;
  logic [FILL_W+4:0] pending_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A timeout that is still within the retry limit draws from the widened window.
  assign attempt_inc = {1'b0, attempt_r} + 5'd1;
  assign widen = (item_r.command == CMD_TIMEOUT) && ({1'b0, maxr_r} >= attempt_r);

  always_comb begin
    mul_a = 16'd0;
    mul_b = 16'd0;
    case (state_r)
      ST_WIN: begin
        mul_a = {6'd0, bw_r};
        mul_b = widen ? {11'd0, attempt_inc} : 16'd1;
      end
      ST_DRAW: begin
        mul_a = item_r.random_draw;
        mul_b = {1'b0, prod_r[14:0]};
      end
      default: begin
        mul_a = 16'd0;
        mul_b = 16'd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign draw_sum = {1'b0, prod_r[31:16]} + 17'd1;
  assign draw = (draw_sum > DRAW_MAX) ? DRAW_MAX[12:0] : draw_sum[12:0];

  assign commit = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    logic finish;
    logic matched;
    finish      = 1'b0;
    matched     = (fill_r != '0) && (item_r.frame_ref == fc_r);
    res         = '0;
    idle_nxt    = idle_r;
    count_nxt   = count_r;
    fc_nxt      = fc_r;
    attempt_nxt = attempt_r;
    drop_nxt    = drop_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    mem_we      = 1'b0;
    mem_wdata.is_ack = (item_r.command == CMD_ENQ_ACK);
    mem_wdata.dest   = item_r.peer;
    mem_wdata.ack_id = (item_r.command == CMD_ENQ_ACK) ? item_r.frame_ref : 16'd0;

    case (item_r.command)
      CMD_ENQ_DATA, CMD_ENQ_ACK: begin
        if (fill_r == FILL_W'(QUEUE_DEPTH)) begin
          res.queue_full = 1'b1;
        end else begin
          mem_we   = 1'b1;
          tail_nxt = (tail_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          fill_nxt = fill_r + 1'b1;
          if (idle_r) begin
            count_nxt = draw;
            idle_nxt  = 1'b0;
          end
        end
      end
      CMD_TICK: begin
        if (!idle_r && count_r != 13'd0) begin
          count_nxt = count_r - 13'd1;
          if (count_r == 13'd1) begin
            if (fill_r == '0) begin
              idle_nxt = 1'b1;
            end else begin
              res.sent      = 1'b1;
              res.sent_dest = mem_rd_r.dest;
              if (mem_rd_r.is_ack) begin
                res.sent_is_ack = 1'b1;
                res.sent_id     = mem_rd_r.ack_id;
                finish          = 1'b1;
              end else begin
                res.sent_id     = fc_r;
                res.start_timer = 1'b1;
                if (attempt_r != ATTEMPT_MAX) begin
                  attempt_nxt = attempt_r + 4'd1;
                end
              end
            end
          end
        end
      end
      CMD_ACK_RX: begin
        finish = matched;
      end
      CMD_TIMEOUT: begin
        if (matched) begin
          if (widen) begin
            count_nxt = draw;
            idle_nxt  = 1'b0;
          end else begin
            drop_nxt        = drop_r + 16'd1;
            res.dropped_now = 1'b1;
            finish          = 1'b1;
          end
        end
      end
      default: begin
        finish = 1'b0;
      end
    endcase

    // The head frame is done: pop it and, if another frame waits, start a base draw for it.
    if (finish) begin
      head_nxt    = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      fill_nxt    = fill_r - 1'b1;
      fc_nxt      = fc_r + 16'd1;
      attempt_nxt = 4'd0;
      if (fill_r == FILL_W'(1)) begin
        idle_nxt  = 1'b1;
        count_nxt = 13'd0;
      end else begin
        idle_nxt  = 1'b0;
        count_nxt = draw;
      end
    end

    pending_ext    = {5'd0, fill_nxt};
    res.drop_total = drop_nxt;
    res.pending    = pending_ext[4:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_WIN;
      ST_WIN:  state_nxt = ST_DRAW;
      ST_DRAW: state_nxt = ST_EXEC;
      ST_EXEC: if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == ST_WIN || state_r == ST_DRAW) begin
      prod_r <= mul_p;
    end
    if (commit) begin
      out_data_r <= res;
    end
  end

  // Frame queue: written at the tail on enqueue, head read registered every cycle.
  always_ff @(posedge clk) begin
    if (commit && mem_we) begin
      fifo_mem[tail_r] <= mem_wdata;
    end
    mem_rd_r <= fifo_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bw_r        <= BACKOFF_WINDOW_RST;
      maxr_r      <= MAX_RETRIES_RST;
      idle_r      <= 1'b1;
      count_r     <= 13'd0;
      fc_r        <= 16'd0;
      attempt_r   <= 4'd0;
      drop_r      <= 16'd0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BACKOFF_WINDOW: bw_r   <= cfg_wdata;
          REG_MAX_RETRIES:    maxr_r <= cfg_wdata[2:0];
          default:            bw_r   <= bw_r;
        endcase
      end
      if (commit) begin
        idle_r    <= idle_nxt;
        count_r   <= count_nxt;
        fc_r      <= fc_nxt;
        attempt_r <= attempt_nxt;
        drop_r    <= drop_nxt;
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        fill_r    <= fill_nxt;
      end
    end
  end

endmodule

[test/testbench.sv]
// Self-checking testbench for the CSMA/CA station sender with backoff and retransmission.
module testbench;
  import csma_pkg::*;

  localparam int QDEPTH = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;

  class station_scoreboard;
    bit [9:0]    window;
    bit [2:0]    retry_limit;
    bit          armed;
    int unsigned backoff_left;
    bit [15:0]   frame_id;
    int unsigned attempts;
    bit [15:0]   drops;
    frame_t      slots [QDEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned fill;
    out_item_t   status_due [$];
    int          mismatches;

    function new();
      window = BACKOFF_WINDOW_RST;
      retry_limit = MAX_RETRIES_RST;
      armed = 1'b0;
      backoff_left = 0;
      frame_id = '0;
      attempts = 0;
      drops = '0;
      head = 0;
      tail = 0;
      fill = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_BACKOFF_WINDOW: window = val;
        REG_MAX_RETRIES: retry_limit = val[2:0];
        default: ;
      endcase
    endfunction

    function void load_backoff(int unsigned span, bit [15:0] rnd);
      longint unsigned d;
      d = rnd;
      d = 1 + ((d * span) >> 16);
      if (d > DRAW_MAX) d = DRAW_MAX;
      backoff_left = 32'(d);
      armed = 1'b1;
    endfunction

    // Returns 1 when the queue was full and the frame was refused.
    function bit enqueue(bit is_ack, bit [5:0] dest, bit [15:0] id, bit [15:0] rnd);
      if (fill >= QDEPTH) return 1'b1;
      slots[tail].is_ack = is_ack;
      slots[tail].dest = dest;
      slots[tail].ack_id = id;
      tail = (tail + 1) % QDEPTH;
      fill++;
      if (!armed) load_backoff(32'(window), rnd);
      return 1'b0;
    endfunction

    function void retire_head(bit [15:0] rnd);
      if (fill > 0) begin
        head = (head + 1) % QDEPTH;
        fill--;
      end
      frame_id++;
      attempts = 0;
      if (fill == 0) begin
        armed = 1'b0;
        backoff_left = 0;
      end else begin
        load_backoff(32'(window), rnd);
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      frame_t    f;
      r = '0;
      case (it.command)
        CMD_ENQ_DATA: r.queue_full = enqueue(1'b0, it.peer, '0, it.random_draw);
        CMD_ENQ_ACK: r.queue_full = enqueue(1'b1, it.peer, it.frame_ref, it.random_draw);
        CMD_TICK: begin
          if (armed && backoff_left > 0) begin
            backoff_left--;
            if (backoff_left == 0) begin
              if (fill == 0) begin
                armed = 1'b0;
              end else begin
                f = slots[head];
                r.sent = 1'b1;
                r.sent_dest = f.dest;
                if (f.is_ack) begin
                  r.sent_is_ack = 1'b1;
                  r.sent_id = f.ack_id;
                  retire_head(it.random_draw);
                end else begin
                  r.sent_id = frame_id;
                  r.start_timer = 1'b1;
                  if (attempts < ATTEMPT_MAX) attempts++;
                end
              end
            end
          end
        end
        CMD_ACK_RX: begin
          if (fill > 0 && it.frame_ref == frame_id) retire_head(it.random_draw);
        end
        CMD_TIMEOUT: begin
          if (fill > 0 && it.frame_ref == frame_id) begin
            if (attempts <= retry_limit) begin
              load_backoff(window * (attempts + 1), it.random_draw);
            end else begin
              drops++;
              r.dropped_now = 1'b1;
              retire_head(it.random_draw);
            end
          end
        end
        default: ;
      endcase
      r.drop_total = drops;
      r.pending = fill[4:0];
      status_due.insert(status_due.size(), r);
    endfunction

    function string status_text(out_item_t s);
      return {$sformatf("sent=%0b ack=%0b dest=%0d id=%h timer=%0b ",
                        s.sent, s.sent_is_ack, s.sent_dest, s.sent_id, s.start_timer),
              $sformatf("drop=%0b full=%0b total=%0d pend=%0d",
                        s.dropped_now, s.queue_full, s.drop_total, s.pending)};
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", status_text(got));
        return;
      end
      exp = status_due[0];
      status_due.delete(0);
      if (got.sent !== exp.sent || got.sent_is_ack !== exp.sent_is_ack ||
          got.sent_dest !== exp.sent_dest || got.sent_id !== exp.sent_id ||
          got.start_timer !== exp.start_timer || got.dropped_now !== exp.dropped_now ||
          got.queue_full !== exp.queue_full || got.drop_total !== exp.drop_total ||
          got.pending !== exp.pending) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected %s", status_text(exp));
          $display("          actual   %s", status_text(got));
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  station_scoreboard sb;
  bit calm;
  int holds_asked;
  int holds_given;
  int hold_left;
  int idle_cycles;

  csma_station_backoff_sender dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off counted here once one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      holds_given <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_given != holds_asked) begin
      holds_given <= holds_given + 1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Valid stays high from one item to the next unless a gap is drawn.
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_cmd(logic [2:0] cmd, logic [5:0] peer, logic [15:0] ref_id,
                          logic [15:0] rnd);
    in_item_t it;
    it.command = cmd;
    it.peer = peer;
    it.frame_ref = ref_id;
    it.random_draw = rnd;
    send_item(it);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [9:0] win, logic [2:0] retries);
    logic [CFG_DATA_W-1:0] val;
    drain();
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BACKOFF_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(REG_BACKOFF_WINDOW, win);
    // The upper bits of the retry write are junk and must be ignored.
    val = {7'($urandom_range(127)), retries};
    cfg_index <= REG_MAX_RETRIES;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(REG_MAX_RETRIES, val);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: acks and timeouts usually name the frame in flight.
  task automatic random_traffic(int count, int enq_pct);
    in_item_t it;
    int pick;
    repeat (count) begin
      it.peer = $urandom_range(63);
      it.frame_ref = $urandom_range(65535);
      it.random_draw = $urandom_range(65535);
      pick = $urandom_range(99);
      if (pick < 4) begin
        it.command = CMD_RESERVED_FIRST + 3'($urandom_range(2));
      end else if (pick < 4 + enq_pct || sb.fill == 0) begin
        it.command = ($urandom_range(3) == 0) ? CMD_ENQ_ACK : CMD_ENQ_DATA;
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) it.command = CMD_TICK;
        else if (pick < 80) it.command = CMD_ACK_RX;
        else it.command = CMD_TIMEOUT;
        if (it.command != CMD_TICK && $urandom_range(9) < 8) it.frame_ref = sb.frame_id;
      end
      send_item(it);
    end
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    holds_asked = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty-queue events and reserved commands change nothing.
    send_cmd(CMD_TICK, 6'd0, 16'h0000, 16'h0000);
    send_cmd(CMD_ACK_RX, 6'd63, 16'h0000, 16'hFFFF);
    send_cmd(CMD_TIMEOUT, 6'd63, 16'h0000, 16'hFFFF);
    send_cmd(CMD_RESERVED_FIRST, 6'd63, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_RESERVED_FIRST + 3'd1, 6'd0, 16'h0000, 16'h0000);
    send_cmd(3'(CMD_RESERVED_FIRST + 3'd2), 6'd63, 16'hFFFF, 16'hFFFF);
    // Data frame, retried once after a timeout, then acked; the ack frame follows.
    send_cmd(CMD_ENQ_DATA, 6'd63, 16'hFFFF, 16'h0000);
    send_cmd(CMD_ENQ_ACK, 6'd0, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_TICK, 6'd0, 16'h0000, 16'hFFFF);
    send_cmd(CMD_TIMEOUT, 6'd0, 16'h0001, 16'h0000);
    send_cmd(CMD_TIMEOUT, 6'd0, 16'h0000, 16'h0000);
    send_cmd(CMD_TICK, 6'd0, 16'h0000, 16'h0000);
    send_cmd(CMD_ACK_RX, 6'd0, 16'h0001, 16'h0000);
    send_cmd(CMD_ACK_RX, 6'd0, 16'h0000, 16'h0000);
    send_cmd(CMD_TICK, 6'd0, 16'h0000, 16'h0000);
    // Largest draw, and a tick that leaves the counter nonzero.
    send_cmd(CMD_ENQ_DATA, 6'd21, 16'h0000, 16'hFFFF);
    send_cmd(CMD_TICK, 6'd42, 16'hAAAA, 16'h5555);

    set_config(10'd0, 3'd0);
    random_traffic(60, 25);

    set_config(10'd1, 3'd7);
    calm = 1'b1;
    random_traffic(80, 20);
    calm = 1'b0;

    set_config(10'd5, 3'd2);
    random_traffic(30, 25);
    holds_asked++;
    random_traffic(70, 25);

    set_config(10'd3, 3'd3);
    random_traffic(40, 20);
    drain();
    random_traffic(40, 20);

    // A wide window keeps frames parked so the queue overflows.
    set_config(10'd1023, 3'd7);
    random_traffic(50, 55);

    set_config(10'd12, 3'd1);
    random_traffic(60, 25);

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.status_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
